// ===== sv/isu_pkg.sv =====
package isu_pkg;

  localparam int OPCODE_W     = 3;
  localparam int POS_W        = 7;
  localparam int WORD_W       = 32;
  localparam int STATUS_W     = 2;
  localparam int COUNT_W      = 7;
  localparam int CAPACITY_DEF = 64;

  typedef enum logic [OPCODE_W-1:0] {
    OP_APPEND   = 3'd0,
    OP_POP_TAIL = 3'd1,
    OP_POP_HEAD = 3'd2,
    OP_READ     = 3'd3,
    OP_INSERT   = 3'd4
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } st_t;

  // per-cycle command broadcast to every cell of the row
  typedef enum logic [2:0] {
    CMD_HOLD,
    CMD_APPEND,
    CMD_POP_HEAD,
    CMD_INSERT,
    CMD_LOAD_TAP,
    CMD_SHIFT_TAP
  } cell_cmd_t;

  typedef enum logic {
    S_IDLE,
    S_SEEK
  } state_t;

endpackage

// ===== sv/isu_cell.sv =====
// One storage slot of the row plus one stage of the read tap line.
module isu_cell #(
  parameter int IDX  = 0,
  parameter int SELW = 7
) (
  input  logic                                clk,
  input  isu_pkg::cell_cmd_t                  cmd,
  input  logic [SELW-1:0]                     sel,
  input  logic signed [isu_pkg::WORD_W-1:0]   word_in,
  input  logic signed [isu_pkg::WORD_W-1:0]   left_word,
  input  logic signed [isu_pkg::WORD_W-1:0]   right_word,
  input  logic signed [isu_pkg::WORD_W-1:0]   right_tap,
  output logic signed [isu_pkg::WORD_W-1:0]   word,
  output logic signed [isu_pkg::WORD_W-1:0]   tap
);

  localparam logic [SELW-1:0] MY_IDX = SELW'(IDX);

  always_ff @(posedge clk) begin
    unique case (cmd)
      isu_pkg::CMD_APPEND: begin
        if (sel == MY_IDX) word <= word_in;
      end
      isu_pkg::CMD_POP_HEAD: begin
        word <= right_word;
      end
      isu_pkg::CMD_INSERT: begin
        // slots at and past the insert point move one place toward the tail
        if (sel == MY_IDX) begin
          word <= word_in;
        end else if (MY_IDX > sel) begin
          word <= left_word;
        end
      end
      isu_pkg::CMD_LOAD_TAP: begin
        tap <= word;
      end
      isu_pkg::CMD_SHIFT_TAP: begin
        tap <= right_tap;
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== sv/indexed_sequence_store_unit.sv =====
// Indexed sequence store: an ordered list of up to CAPACITY signed 32-bit
// words, used as a double-ended queue with positional read and insert.
// Input channel (in_valid/in_ready): opcode, position, word_in. Output
// channel (out_valid/out_ready): word_out, status, count. Every input
// transaction yields exactly one output transaction, in order.
// Storage is a row of cells. Append writes one cell, insert shifts the
// cells from the insert point on and remove-head shifts every cell, all in
// the accept cycle; their result is valid in the cycle after acceptance.
// Read and remove-tail copy the row into a tap line that walks toward
// the head one cell per cycle until the wanted slot reaches cell 0.
// Errors (empty, position out of range, full, unused opcode) finish
// without a seek and leave the store unchanged.
// One operation is in flight at a time; a new transaction is taken when the
// unit is idle and the output register is empty or being drained.
// Throughput with a ready receiver: one transaction per cycle for append,
// insert, remove-head and errors; none during a read or remove-tail seek.
// A stalled receiver holds the output register; further input is then held
// off. Synchronous reset empties the store (count zero) and clears the
// output valid; word contents are not cleared and are never read unwritten.
module indexed_sequence_store_unit #(
  parameter int CAPACITY = isu_pkg::CAPACITY_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [isu_pkg::OPCODE_W-1:0]          opcode,
  input  logic [isu_pkg::POS_W-1:0]             position,
  input  logic signed [isu_pkg::WORD_W-1:0]     word_in,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [isu_pkg::WORD_W-1:0]     word_out,
  output logic [isu_pkg::STATUS_W-1:0]          status,
  output logic [isu_pkg::COUNT_W-1:0]           count
);

  localparam int CW   = $clog2(CAPACITY + 1);           // occupancy width
  localparam int IW   = $clog2(CAPACITY);               // slot index width
  localparam int CMPW = (CW > isu_pkg::POS_W) ? CW : isu_pkg::POS_W;
  localparam int WW   = isu_pkg::WORD_W;

  isu_pkg::state_t    state, state_next;
  isu_pkg::cell_cmd_t cell_cmd;
  logic [CW-1:0]      cell_sel;

  logic [CW-1:0]      occupancy;
  logic [IW-1:0]      seek_cnt;

  logic signed [WW-1:0] words [CAPACITY];
  logic signed [WW-1:0] taps  [CAPACITY+1];

  // decode of the offered transaction
  isu_pkg::st_t       dec_status;
  logic               dec_seek;
  isu_pkg::cell_cmd_t dec_cmd;
  logic [CW-1:0]      dec_sel;
  logic [CW-1:0]      dec_occ;
  logic signed [WW-1:0] dec_word;
  logic [IW-1:0]      dec_idx;

  logic accept, slot_free, finish, full, empty;
  logic [CMPW-1:0] pos_ext, occ_ext;

  assign slot_free = !out_valid || out_ready;
  assign in_ready  = (state == isu_pkg::S_IDLE) && slot_free;
  assign accept    = in_valid && in_ready;
  assign finish    = (state == isu_pkg::S_SEEK) && (seek_cnt == '0) && slot_free;

  assign full    = (occupancy == CW'(CAPACITY));
  assign empty   = (occupancy == '0);
  assign pos_ext = CMPW'(position);
  assign occ_ext = CMPW'(occupancy);

  always_comb begin
    dec_status = isu_pkg::ST_OK;
    dec_seek   = 1'b0;
    dec_cmd    = isu_pkg::CMD_HOLD;
    dec_sel    = occupancy;
    dec_occ    = occupancy;
    dec_word   = '0;
    dec_idx    = '0;
    unique case (opcode)
      isu_pkg::OP_APPEND: begin
        if (full) begin
          dec_status = isu_pkg::ST_FULL;
        end else begin
          dec_cmd = isu_pkg::CMD_APPEND;
          dec_occ = occupancy + CW'(1);
        end
      end
      isu_pkg::OP_POP_TAIL: begin
        if (empty) begin
          dec_status = isu_pkg::ST_RANGE;
        end else begin
          dec_seek = 1'b1;
          dec_cmd  = isu_pkg::CMD_LOAD_TAP;
          dec_occ  = occupancy - CW'(1);
          dec_idx  = IW'(occupancy - CW'(1));
        end
      end
      isu_pkg::OP_POP_HEAD: begin
        if (empty) begin
          dec_status = isu_pkg::ST_RANGE;
        end else begin
          dec_cmd  = isu_pkg::CMD_POP_HEAD;
          dec_occ  = occupancy - CW'(1);
          dec_word = words[0];
        end
      end
      isu_pkg::OP_READ: begin
        if (pos_ext >= occ_ext) begin
          dec_status = isu_pkg::ST_RANGE;
        end else begin
          dec_seek = 1'b1;
          dec_cmd  = isu_pkg::CMD_LOAD_TAP;
          dec_idx  = IW'(pos_ext);
        end
      end
      isu_pkg::OP_INSERT: begin
        // range check ranks above the full check
        if (pos_ext > occ_ext) begin
          dec_status = isu_pkg::ST_RANGE;
        end else if (full) begin
          dec_status = isu_pkg::ST_FULL;
        end else begin
          dec_cmd = isu_pkg::CMD_INSERT;
          dec_sel = CW'(pos_ext);
          dec_occ = occupancy + CW'(1);
        end
      end
      default: begin
        dec_status = isu_pkg::ST_RANGE;
      end
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      isu_pkg::S_IDLE: begin
        if (accept && dec_seek) state_next = isu_pkg::S_SEEK;
      end
      isu_pkg::S_SEEK: begin
        if (finish) state_next = isu_pkg::S_IDLE;
      end
      default: state_next = isu_pkg::S_IDLE;
    endcase
  end

  // row command
  always_comb begin
    cell_cmd = isu_pkg::CMD_HOLD;
    cell_sel = dec_sel;
    unique case (state)
      isu_pkg::S_IDLE: begin
        if (accept) cell_cmd = dec_cmd;
      end
      isu_pkg::S_SEEK: begin
        if (seek_cnt != '0) cell_cmd = isu_pkg::CMD_SHIFT_TAP;
      end
      default: cell_cmd = isu_pkg::CMD_HOLD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= isu_pkg::S_IDLE;
      occupancy <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) occupancy <= dec_occ;
      if ((accept && !dec_seek) || finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload: seek counter and output register
  always_ff @(posedge clk) begin
    if (accept) begin
      seek_cnt <= dec_idx;
    end else if (state == isu_pkg::S_SEEK && seek_cnt != '0) begin
      seek_cnt <= seek_cnt - IW'(1);
    end
    if (accept && !dec_seek) begin
      word_out <= dec_word;
      status   <= dec_status;
      count    <= isu_pkg::COUNT_W'(dec_occ);
    end else if (finish) begin
      word_out <= taps[0];
      status   <= isu_pkg::ST_OK;
      count    <= isu_pkg::COUNT_W'(occupancy);
    end
  end

  // the row of cells; tap line drains toward cell 0
  assign taps[CAPACITY] = '0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [WW-1:0] left_w, right_w;
    if (i == 0) begin : g_head
      assign left_w = word_in;
    end else begin : g_mid_l
      assign left_w = words[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign right_w = words[i];
    end else begin : g_mid_r
      assign right_w = words[i+1];
    end

    isu_cell #(
      .IDX  (i),
      .SELW (CW)
    ) u_cell (
      .clk        (clk),
      .cmd        (cell_cmd),
      .sel        (cell_sel),
      .word_in    (word_in),
      .left_word  (left_w),
      .right_word (right_w),
      .right_tap  (taps[i+1]),
      .word       (words[i]),
      .tap        (taps[i])
    );
  end

endmodule
